@@ sv/wbj_pkg.sv @@
`default_nettype none
package wbj_pkg;

	// Storage and field sizes.
	localparam int MAX_BLOCKS      = 1024;
	localparam int VALUE_FRAC_BITS = 24;
	localparam int WSHIFT          = 32 - VALUE_FRAC_BITS;
	localparam int ADDR_W          = $clog2(MAX_BLOCKS);
	localparam int CNT_W           = $clog2(MAX_BLOCKS + 1);
	localparam int VAL_W           = 32;
	localparam int LEN_W           = 24;
	localparam int LSUM_W          = LEN_W + CNT_W;
	localparam int VSUM_W          = VAL_W + CNT_W;
	localparam int WSUM_W          = VAL_W + LEN_W + 1 + CNT_W;
	localparam int EST_W           = 48;
	localparam int VAR_W           = 64;
	localparam int ST_W            = 2;
	localparam int BU_W            = 11;
	localparam int RIDX_W          = 1;
	localparam int RDATA_W         = 32;

	// Wide datapath, divider and multiplier sizes.
	localparam int W         = 128;
	localparam int DV_W      = LSUM_W;
	localparam int DIV_RADIX = 4;
	localparam int DIV_ITERS = W / DIV_RADIX;
	localparam int DCNT_W    = $clog2(DIV_ITERS);
	localparam int MA_W      = 96;
	localparam int MB_W      = 64;
	localparam int CLAMP_BIT = 120;

	// Result status codes.
	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_NO_BLOCKS = 2'd1;
	localparam logic [ST_W-1:0] ST_ZERO_DEN  = 2'd2;

	// Configuration register indexes.
	localparam logic [RIDX_W-1:0] REG_TOTAL_GIVEN    = 1'b0;
	localparam logic [RIDX_W-1:0] REG_TOTAL_ESTIMATE = 1'b1;

	typedef enum logic [4:0] {
		S_LOAD, S_CHECK, S_WMEAN, S_EST, S_ESTW, S_CISS, S_CW,
		S_RD, S_T0, S_M1, S_M2, S_D1, S_M3, S_D2, S_M4, S_ACC,
		S_VAR, S_VW, S_EMIT
	} phase_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	// Magnitude of a signed 64-bit value.
	function automatic logic [63:0] abs64(input logic signed [63:0] x);
		abs64 = x[63] ? 64'(-x) : 64'(x);
	endfunction

	// Magnitude of a signed wide value.
	function automatic logic [W-1:0] absw(input logic signed [W-1:0] x);
		absw = x[W-1] ? W'(-x) : W'(x);
	endfunction

	// Saturate a wide signed value to the estimate width.
	function automatic logic signed [EST_W-1:0] sat_est(input logic signed [W-1:0] x);
		logic same;
		same = (&x[W-1:EST_W-1]) || !(|x[W-1:EST_W-1]);
		if (same) begin
			sat_est = x[EST_W-1:0];
		end else if (x[W-1]) begin
			sat_est = {1'b1, {(EST_W-1){1'b0}}};
		end else begin
			sat_est = {1'b0, {(EST_W-1){1'b1}}};
		end
	endfunction

	// Clamp a non-negative accumulator at two to the power CLAMP_BIT.
	function automatic logic [W-1:0] clamp_acc(input logic [W-1:0] x);
		if (!x[W-1] && (|x[W-2:CLAMP_BIT])) begin
			clamp_acc = W'(1) << CLAMP_BIT;
		end else begin
			clamp_acc = x;
		end
	endfunction

endpackage
`default_nettype wire

@@ sv/wbj_ifs.sv @@
`default_nettype none
interface wbj_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [wbj_pkg::VAL_W-1:0]  loo_value;
	logic                              value_missing;
	logic        [wbj_pkg::LEN_W-1:0]  block_length;
	logic                              last_block;
	modport source(output valid, loo_value, value_missing, block_length, last_block,
		input ready);
	modport sink(input valid, loo_value, value_missing, block_length, last_block,
		output ready);
endinterface

interface wbj_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [wbj_pkg::EST_W-1:0]  estimate;
	logic        [wbj_pkg::VAR_W-1:0]  variance;
	logic        [wbj_pkg::ST_W-1:0]   status;
	logic        [wbj_pkg::BU_W-1:0]   blocks_used;
	modport source(output valid, estimate, variance, status, blocks_used, input ready);
	modport sink(input valid, estimate, variance, status, blocks_used, output ready);
endinterface

interface wbj_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [wbj_pkg::RIDX_W-1:0]        reg_index;
	logic [wbj_pkg::RDATA_W-1:0]       wdata;
	modport source(output valid, reg_index, wdata, input ready);
	modport sink(input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

@@ sv/wbj_div.sv @@
`default_nettype none
module wbj_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [wbj_pkg::W-1:0]    dividend,
	input  wire logic [wbj_pkg::DV_W-1:0] divisor,
	output logic      [wbj_pkg::W-1:0]    quotient,
	output wbj_pkg::unit_stat_t           stat
);

	logic [wbj_pkg::W-1:0]      dq_q, dq_n;
	logic [wbj_pkg::DV_W:0]     rem_q, rem_n;
	logic [wbj_pkg::DV_W-1:0]   dvs_q;
	logic [wbj_pkg::DCNT_W-1:0] cnt_q;
	logic                       busy_q, done_q;

	// Restoring division, several quotient bits per cycle.
	always_comb begin
		logic [wbj_pkg::W-1:0]  d;
		logic [wbj_pkg::DV_W:0] r;
		d = dq_q;
		r = rem_q;
		for (int k = 0; k < wbj_pkg::DIV_RADIX; k++) begin
			r = {r[wbj_pkg::DV_W-1:0], d[wbj_pkg::W-1]};
			d = {d[wbj_pkg::W-2:0], 1'b0};
			if (r >= {1'b0, dvs_q}) begin
				r = r - {1'b0, dvs_q};
				d[0] = 1'b1;
			end
		end
		dq_n = d;
		rem_n = r;
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == wbj_pkg::DCNT_W'(wbj_pkg::DIV_ITERS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q <= dq_n;
			rem_q <= rem_n;
		end
	end

	assign quotient = dq_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
`default_nettype wire

@@ sv/wbj_mul.sv @@
`default_nettype none
module wbj_mul (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [wbj_pkg::MA_W-1:0] a,
	input  wire logic [wbj_pkg::MB_W-1:0] b,
	output logic      [wbj_pkg::W-1:0]    product,
	output wbj_pkg::unit_stat_t           stat
);

	logic [wbj_pkg::MA_W-1:0] a_q;
	logic [wbj_pkg::MB_W-1:0] b_q;
	logic [1:0]               ia_q;
	logic                     jb_q;
	logic                     iss_q, done_q;
	logic [63:0]              p_s1;
	logic [1:0]               sh_s1;
	logic                     vld_s1;
	logic [wbj_pkg::W-1:0]    acc_q, shifted;
	logic [31:0]              a_ch, b_ch;

	// Chunk selection for the current partial product.
	always_comb begin
		case (ia_q)
			2'd0:    a_ch = a_q[31:0];
			2'd1:    a_ch = a_q[63:32];
			default: a_ch = a_q[95:64];
		endcase
		b_ch = jb_q ? b_q[63:32] : b_q[31:0];
	end

	// Align the registered partial product.
	always_comb begin
		case (sh_s1)
			2'd0:    shifted = {64'b0, p_s1};
			2'd1:    shifted = {32'b0, p_s1, 32'b0};
			2'd2:    shifted = {p_s1, 64'b0};
			default: shifted = {p_s1[31:0], 96'b0};
		endcase
	end

	// Sequencing over the six partial products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ia_q <= '0;
			jb_q <= 1'b0;
			iss_q <= 1'b0;
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			ia_q <= '0;
			jb_q <= 1'b0;
			iss_q <= 1'b1;
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= iss_q;
			done_q <= vld_s1 && !iss_q;
			if (iss_q) begin
				if (ia_q == 2'd2) begin
					ia_q <= '0;
					if (jb_q) begin
						iss_q <= 1'b0;
					end else begin
						jb_q <= 1'b1;
					end
				end else begin
					ia_q <= ia_q + 2'd1;
				end
			end
		end
	end

	// One 32 by 32 product a cycle, then accumulate.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end else begin
			if (iss_q) begin
				p_s1 <= a_ch * b_ch;
				sh_s1 <= ia_q + {1'b0, jb_q};
			end
			if (vld_s1) begin
				acc_q <= acc_q + shifted;
			end
		end
	end

	assign product = acc_q;
	assign stat.busy = iss_q | vld_s1;
	assign stat.done = done_q;

endmodule
`default_nettype wire

@@ sv/weighted_block_jackknife_top.sv @@
`default_nettype none
// Channel  Role    Payload
// cfg      sink    reg_index, wdata (total_given, total_estimate)
// items    sink    loo_value, value_missing, block_length, last_block
// results  source  estimate, variance, status, blocks_used
//
// Loading takes one item per cycle. The item marked last starts a second pass over
// the stored blocks unless there are none or a denominator is zero. Each block runs
// through the multiplier and the divider, with more steps per block with a full-data
// total than in mean mode.
// Reset clears sums, block count, settings and result valid; the store needs no clearing.
// Items are refused until a set's result is emitted; a waiting result delays the next one's emit.
module weighted_block_jackknife_top (
	input wire logic  clk,
	input wire logic  arst_n,
	wbj_cfg_if.sink   cfg,
	wbj_in_if.sink    items,
	wbj_out_if.source results
);

	localparam int VW  = wbj_pkg::VAL_W;
	localparam int LW  = wbj_pkg::LEN_W;
	localparam int CW  = wbj_pkg::CNT_W;
	localparam int WW  = wbj_pkg::W;
	localparam int DW  = wbj_pkg::DV_W;

	wbj_pkg::phase_t state_q, state_d;

	logic                            tg_q;
	logic signed [VW-1:0]            tot_q;
	logic [CW-1:0]                   cnt_q, idx_q;
	logic [wbj_pkg::LSUM_W-1:0]      lsum_q;
	logic signed [wbj_pkg::VSUM_W-1:0] vsum_q;
	logic signed [wbj_pkg::WSUM_W-1:0] wsum_q;
	logic                            zlen_q;

	logic [VW+LW-1:0]                store_mem [wbj_pkg::MAX_BLOCKS];
	logic [VW+LW-1:0]                rd_q;

	logic [LW-1:0]                   len_q;
	logic [DW-1:0]                   m_q;
	logic                            sgn_q;
	logic signed [WW-1:0]            wmean_q, base_q;
	logic signed [wbj_pkg::EST_W-1:0] est_q;
	logic signed [63:0]              c_q, u_q;
	logic [wbj_pkg::MA_W-1:0]        cc_q;
	logic [WW-1:0]                   term_q, acc_q;
	logic [wbj_pkg::VAR_W-1:0]       var_q;
	logic [wbj_pkg::ST_W-1:0]        status_q;

	logic                            out_valid_q;
	logic signed [wbj_pkg::EST_W-1:0] out_est_q;
	logic [wbj_pkg::VAR_W-1:0]       out_var_q;
	logic [wbj_pkg::ST_W-1:0]        out_st_q;
	logic [wbj_pkg::BU_W-1:0]        out_bu_q;

	// Shared arithmetic units.
	logic                       mul_start, div_start;
	logic [wbj_pkg::MA_W-1:0]   mul_a;
	logic [wbj_pkg::MB_W-1:0]   mul_b;
	logic [WW-1:0]              mul_p, div_n, div_q;
	logic [DW-1:0]              div_d;
	wbj_pkg::unit_stat_t        mul_st, div_st;

	wbj_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.product(mul_p), .stat(mul_st)
	);

	wbj_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_n), .divisor(div_d),
		.quotient(div_q), .stat(div_st)
	);

	// Handshakes.
	logic item_acc, store_en, emit;
	assign cfg.ready = 1'b1;
	assign items.ready = (state_q == wbj_pkg::S_LOAD);
	assign item_acc = items.valid && items.ready;
	assign store_en = item_acc && !items.value_missing
		&& (cnt_q < CW'(wbj_pkg::MAX_BLOCKS));
	assign emit = (state_q == wbj_pkg::S_EMIT) && (!out_valid_q || results.ready);

	// Arithmetic feeding the sequencer.
	logic signed [VW+LW:0]    prod_vl;
	logic signed [CW+VW:0]    bt;
	logic signed [WW-1:0]     wsum_w, base_d, num_d, q_sgn;
	logic signed [VW-1:0]     v_rd;
	logic [LW-1:0]            len_rd;
	logic signed [63:0]       c_d, d_d, u_d;
	logic [DW-1:0]            m_d;
	logic [WW-1:0]            t2_mag, t2;
	logic                     no_blk, zden, last_blk;

	assign prod_vl = items.loo_value * $signed({1'b0, items.block_length});
	assign bt = $signed({1'b0, cnt_q}) * tot_q;
	assign wsum_w = WW'(wsum_q);
	assign base_d = WW'(bt) - WW'(vsum_q);
	assign num_d = (WW'(vsum_q) <<< wbj_pkg::WSHIFT) - wmean_q;
	assign q_sgn = sgn_q ? -$signed(div_q) : $signed(div_q);
	assign v_rd = rd_q[VW-1:0];
	assign len_rd = rd_q[VW+:LW];
	assign c_d = (64'(tot_q) <<< wbj_pkg::WSHIFT) - 64'(est_q);
	assign d_d = 64'(est_q) - (64'(v_rd) <<< wbj_pkg::WSHIFT);
	assign u_d = (64'(tot_q) - 64'(v_rd)) <<< wbj_pkg::WSHIFT;
	assign m_d = lsum_q - DW'(len_rd);
	assign t2_mag = mul_p >> 31;
	assign t2 = (c_q[63] != u_q[63]) ? WW'(-t2_mag) : t2_mag;
	assign no_blk = (cnt_q == '0);
	assign zden = (lsum_q == '0) || (cnt_q < CW'(2)) || zlen_q;
	assign last_blk = (CW'(idx_q + CW'(1)) == cnt_q);

	// Next phase.
	always_comb begin
		state_d = state_q;
		case (state_q)
			wbj_pkg::S_LOAD:  if (item_acc && items.last_block) state_d = wbj_pkg::S_CHECK;
			wbj_pkg::S_CHECK: state_d = (no_blk || zden) ? wbj_pkg::S_EMIT : wbj_pkg::S_WMEAN;
			wbj_pkg::S_WMEAN: if (div_st.done) state_d = wbj_pkg::S_EST;
			wbj_pkg::S_EST:   state_d = tg_q ? wbj_pkg::S_CISS : wbj_pkg::S_ESTW;
			wbj_pkg::S_ESTW:  if (div_st.done) state_d = wbj_pkg::S_RD;
			wbj_pkg::S_CISS:  state_d = wbj_pkg::S_CW;
			wbj_pkg::S_CW:    if (mul_st.done) state_d = wbj_pkg::S_RD;
			wbj_pkg::S_RD:    state_d = wbj_pkg::S_T0;
			wbj_pkg::S_T0:    state_d = wbj_pkg::S_M1;
			wbj_pkg::S_M1:    if (mul_st.done) state_d = wbj_pkg::S_M2;
			wbj_pkg::S_M2:    if (mul_st.done) state_d = wbj_pkg::S_D1;
			wbj_pkg::S_D1:    if (div_st.done) state_d = tg_q ? wbj_pkg::S_M3 : wbj_pkg::S_ACC;
			wbj_pkg::S_M3:    if (mul_st.done) state_d = wbj_pkg::S_D2;
			wbj_pkg::S_D2:    if (div_st.done) state_d = wbj_pkg::S_M4;
			wbj_pkg::S_M4:    if (mul_st.done) state_d = wbj_pkg::S_ACC;
			wbj_pkg::S_ACC:   state_d = last_blk ? wbj_pkg::S_VAR : wbj_pkg::S_RD;
			wbj_pkg::S_VAR:   state_d = acc_q[WW-1] ? wbj_pkg::S_EMIT : wbj_pkg::S_VW;
			wbj_pkg::S_VW:    if (div_st.done) state_d = wbj_pkg::S_EMIT;
			wbj_pkg::S_EMIT:  if (emit) state_d = wbj_pkg::S_LOAD;
			default:          state_d = wbj_pkg::S_LOAD;
		endcase
	end

	// Unit starts and operands for each phase.
	always_comb begin
		mul_start = 1'b0;
		mul_a = '0;
		mul_b = '0;
		div_start = 1'b0;
		div_n = '0;
		div_d = '0;
		case (state_q)
			wbj_pkg::S_CHECK: begin
				if (!no_blk && !zden) begin
					div_start = 1'b1;
					div_n = wbj_pkg::absw(wsum_w <<< wbj_pkg::WSHIFT);
					div_d = lsum_q;
				end
			end
			wbj_pkg::S_EST: begin
				if (!tg_q) begin
					div_start = 1'b1;
					div_n = wbj_pkg::absw(num_d);
					div_d = DW'(cnt_q - CW'(1));
				end
			end
			wbj_pkg::S_CISS: begin
				mul_start = 1'b1;
				mul_a = wbj_pkg::MA_W'(wbj_pkg::abs64(c_d));
				mul_b = wbj_pkg::abs64(c_d);
			end
			wbj_pkg::S_T0: begin
				mul_start = 1'b1;
				mul_a = wbj_pkg::MA_W'(wbj_pkg::abs64(tg_q ? u_d : d_d));
				mul_b = wbj_pkg::abs64(tg_q ? u_d : d_d);
			end
			wbj_pkg::S_M1: begin
				if (mul_st.done) begin
					mul_start = 1'b1;
					mul_a = mul_p[WW-1:32];
					mul_b = wbj_pkg::MB_W'(m_q);
				end
			end
			wbj_pkg::S_M2: begin
				if (mul_st.done) begin
					div_start = 1'b1;
					div_n = mul_p;
					div_d = DW'(len_q);
				end
			end
			wbj_pkg::S_D1: begin
				if (div_st.done && tg_q) begin
					mul_start = 1'b1;
					mul_a = cc_q;
					mul_b = wbj_pkg::MB_W'(len_q);
				end
			end
			wbj_pkg::S_M3: begin
				if (mul_st.done) begin
					div_start = 1'b1;
					div_n = mul_p;
					div_d = m_q;
				end
			end
			wbj_pkg::S_D2: begin
				if (div_st.done) begin
					mul_start = 1'b1;
					mul_a = wbj_pkg::MA_W'(wbj_pkg::abs64(c_q));
					mul_b = wbj_pkg::abs64(u_q);
				end
			end
			wbj_pkg::S_VAR: begin
				if (!acc_q[WW-1]) begin
					div_start = 1'b1;
					div_n = acc_q;
					div_d = DW'(cnt_q);
				end
			end
			default: begin
			end
		endcase
	end

	// Control state, running sums and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wbj_pkg::S_LOAD;
			tg_q <= 1'b0;
			tot_q <= '0;
			cnt_q <= '0;
			lsum_q <= '0;
			vsum_q <= '0;
			wsum_q <= '0;
			zlen_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				if (cfg.reg_index == wbj_pkg::REG_TOTAL_GIVEN) begin
					tg_q <= cfg.wdata[0];
				end else if (cfg.reg_index == wbj_pkg::REG_TOTAL_ESTIMATE) begin
					tot_q <= cfg.wdata;
				end
			end
			if (store_en) begin
				cnt_q <= cnt_q + CW'(1);
				lsum_q <= lsum_q + wbj_pkg::LSUM_W'(items.block_length);
				vsum_q <= vsum_q + wbj_pkg::VSUM_W'(items.loo_value);
				wsum_q <= wsum_q + wbj_pkg::WSUM_W'(prod_vl);
				if (items.block_length == '0) begin
					zlen_q <= 1'b1;
				end
			end
			if (emit) begin
				cnt_q <= '0;
				lsum_q <= '0;
				vsum_q <= '0;
				wsum_q <= '0;
				zlen_q <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Block store: one write port for loading, one registered read for the pass.
	always_ff @(posedge clk) begin
		if (store_en) begin
			store_mem[cnt_q[wbj_pkg::ADDR_W-1:0]] <= {items.block_length, items.loo_value};
		end
		if (state_q == wbj_pkg::S_RD) begin
			rd_q <= store_mem[idx_q[wbj_pkg::ADDR_W-1:0]];
		end
	end

	// Second-pass datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			wbj_pkg::S_CHECK: begin
				status_q <= no_blk ? wbj_pkg::ST_NO_BLOCKS
					: (zden ? wbj_pkg::ST_ZERO_DEN : wbj_pkg::ST_OK);
				est_q <= '0;
				var_q <= '0;
				acc_q <= '0;
				idx_q <= '0;
				base_q <= base_d;
				sgn_q <= wsum_q[wbj_pkg::WSUM_W-1];
			end
			wbj_pkg::S_WMEAN: if (div_st.done) wmean_q <= q_sgn;
			wbj_pkg::S_EST: begin
				if (tg_q) begin
					est_q <= wbj_pkg::sat_est((base_q <<< wbj_pkg::WSHIFT) + wmean_q);
				end else begin
					sgn_q <= num_d[WW-1];
				end
			end
			wbj_pkg::S_ESTW: if (div_st.done) est_q <= wbj_pkg::sat_est(q_sgn);
			wbj_pkg::S_CISS: c_q <= c_d;
			wbj_pkg::S_CW:   if (mul_st.done) cc_q <= mul_p[WW-1:32];
			wbj_pkg::S_T0: begin
				len_q <= len_rd;
				m_q <= m_d;
				u_q <= u_d;
			end
			wbj_pkg::S_D1:   if (div_st.done) term_q <= div_q;
			wbj_pkg::S_D2:   if (div_st.done) term_q <= term_q + div_q;
			wbj_pkg::S_M4:   if (mul_st.done) term_q <= term_q + t2;
			wbj_pkg::S_ACC: begin
				acc_q <= wbj_pkg::clamp_acc(acc_q + term_q);
				idx_q <= idx_q + CW'(1);
			end
			wbj_pkg::S_VW: begin
				if (div_st.done) begin
					var_q <= (|div_q[WW-1:64]) ? '1 : div_q[63:0];
				end
			end
			default: begin
			end
		endcase
		if (emit) begin
			out_est_q <= est_q;
			out_var_q <= var_q;
			out_st_q <= status_q;
			out_bu_q <= wbj_pkg::BU_W'(cnt_q);
		end
	end

	assign results.valid = out_valid_q;
	assign results.estimate = out_est_q;
	assign results.variance = out_var_q;
	assign results.status = out_st_q;
	assign results.blocks_used = out_bu_q;

	// The multiplier and divider are never run at the same time.
	a_units_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_st.busy && div_st.busy))
		else $error("multiplier and divider busy together");

	// The block count never passes the store depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(wbj_pkg::MAX_BLOCKS))
		else $error("block count beyond store depth");

	// A result appears only out of the emit phase.
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == wbj_pkg::S_EMIT))
		else $error("result raised outside emit phase");

	// Reads during the pass stay within the stored blocks.
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wbj_pkg::S_RD) |-> (idx_q < cnt_q))
		else $error("store read beyond block count");

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [wbj_pkg::EST_W-1:0] estimate;
		logic [wbj_pkg::VAR_W-1:0] variance;
		logic [wbj_pkg::ST_W-1:0]  status;
		logic [wbj_pkg::BU_W-1:0]  blocks_used;
	} jk_result_t;

	localparam longint SCALE   = longint'(1) << wbj_pkg::WSHIFT;
	localparam longint EST_TOP = (longint'(1) << 47) - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	wbj_cfg_if cfg_if();
	wbj_in_if  in_if();
	wbj_out_if out_if();

	weighted_block_jackknife_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if),
		.items(in_if),
		.results(out_if)
	);

	always #5 clk = ~clk;

	// Model state for the current data set and the configuration.
	int                 stored_value [wbj_pkg::MAX_BLOCKS];
	logic [wbj_pkg::LEN_W-1:0] stored_length [wbj_pkg::MAX_BLOCKS];
	int unsigned        set_blocks;
	logic [63:0]        set_length_sum;
	longint             set_value_sum;
	logic signed [127:0] set_weighted_sum;
	bit                 mode_total;
	longint             full_total;

	jk_result_t expected_results[$];
	int  errors = 0;
	int  burst_left = 0;
	bit  gaps_on = 1'b1;
	bit  hold_req = 1'b0;
	int  hold_left = 0;
	int  stall_mode = 0;
	int  mode_left = 0;

	initial begin
		cfg_if.valid = 1'b0;
		cfg_if.reg_index = '0;
		cfg_if.wdata = '0;
		in_if.valid = 1'b0;
		in_if.loo_value = '0;
		in_if.value_missing = 1'b0;
		in_if.block_length = '0;
		in_if.last_block = 1'b0;
		out_if.ready = 1'b0;
	end

	function automatic logic [63:0] magnitude(longint x);
		logic [63:0] r;
		r = x;
		return x < 0 ? -r : r;
	endfunction

	// Signed wide division by an unsigned divisor, truncating toward zero.
	function automatic logic [127:0] div_signed(logic [127:0] a, logic [63:0] d);
		logic [127:0] ab, q;
		if (d == 0) return '0;
		ab = a[127] ? -a : a;
		q = ab / {64'b0, d};
		return a[127] ? -q : q;
	endfunction

	function automatic longint saturate_estimate(logic [127:0] a);
		if ((&a[127:47]) || !(|a[127:47])) return longint'($signed(a[47:0]));
		return a[127] ? -EST_TOP - 1 : EST_TOP;
	endfunction

	function automatic logic [127:0] clamp_sum(logic [127:0] a);
		if (!a[127] && (|a[126:120])) return 128'(1) << 120;
		return a;
	endfunction

	function automatic void clear_set();
		set_blocks = 0;
		set_length_sum = 0;
		set_value_sum = 0;
		set_weighted_sum = 0;
	endfunction

	// Second pass over a closed data set: estimate, variance and status.
	function automatic jk_result_t jackknife_of_set();
		jk_result_t r;
		int unsigned b;
		logic [63:0] n, len, m, mc, mu;
		logic [1:0] st;
		longint est, c, u, d;
		logic [127:0] acc, wmean, num, t1, t2, t3, sq, q;
		logic signed [127:0] ext;
		logic [63:0] var_out;
		b = set_blocks;
		n = set_length_sum;
		st = wbj_pkg::ST_OK;
		est = 0;
		acc = 0;
		var_out = 0;
		if (b == 0) begin
			st = wbj_pkg::ST_NO_BLOCKS;
		end else begin
			if (n == 0 || (!mode_total && b < 2)) st = wbj_pkg::ST_ZERO_DEN;
			for (int unsigned i = 0; i < b; i++)
				if (stored_length[i] == 0 || (mode_total && stored_length[i] == n))
					st = wbj_pkg::ST_ZERO_DEN;
		end
		if (st == wbj_pkg::ST_OK) begin
			wmean = div_signed(set_weighted_sum << wbj_pkg::WSHIFT, n);
			if (!mode_total) begin
				ext = set_value_sum;
				num = (ext << wbj_pkg::WSHIFT) - wmean;
				est = saturate_estimate(div_signed(num, b - 1));
				for (int unsigned i = 0; i < b; i++) begin
					len = stored_length[i];
					d = est - longint'(stored_value[i]) * SCALE;
					mc = magnitude(d);
					sq = ({64'b0, mc} * {64'b0, mc}) >> 32;
					acc = clamp_sum(acc + (sq * (n - len)) / {64'b0, len});
				end
			end else begin
				ext = longint'(b) * full_total - set_value_sum;
				est = saturate_estimate((ext << wbj_pkg::WSHIFT) + wmean);
				c = full_total * SCALE - est;
				mc = magnitude(c);
				for (int unsigned i = 0; i < b; i++) begin
					len = stored_length[i];
					m = n - len;
					u = (full_total - longint'(stored_value[i])) * SCALE;
					mu = magnitude(u);
					t1 = ((({64'b0, mc} * {64'b0, mc}) >> 32) * len) / {64'b0, m};
					t2 = ({64'b0, mc} * {64'b0, mu}) >> 31;
					if ((c < 0) != (u < 0)) t2 = -t2;
					t3 = ((({64'b0, mu} * {64'b0, mu}) >> 32) * m) / {64'b0, len};
					acc = clamp_sum(acc + t1 + t2 + t3);
				end
			end
			if (!acc[127]) begin
				q = acc / 128'(b);
				var_out = (q[127:64] != 0) ? '1 : q[63:0];
			end
		end
		r.estimate = est[47:0];
		r.variance = var_out;
		r.status = st;
		r.blocks_used = b[wbj_pkg::BU_W-1:0];
		return r;
	endfunction

	// Model of one accepted item.
	function automatic void take_item(logic [31:0] v, bit miss, logic [23:0] len, bit last);
		logic signed [127:0] sv;
		if (!miss && set_blocks < wbj_pkg::MAX_BLOCKS) begin
			stored_value[set_blocks] = int'(v);
			stored_length[set_blocks] = len;
			set_length_sum += len;
			set_value_sum += longint'(int'(v));
			sv = int'(v);
			set_weighted_sum = set_weighted_sum + sv * $signed({104'b0, len});
			set_blocks++;
		end
		if (last) begin
			expected_results.push_back(jackknife_of_set());
			clear_set();
		end
	endfunction

	// Offer one item, with bursts and gaps, and record it once accepted.
	task automatic send_item(logic [31:0] v, bit miss, logic [23:0] len, bit last);
		if (burst_left == 0) begin
			if (gaps_on) begin
				in_if.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		in_if.valid <= 1'b1;
		in_if.loo_value <= v;
		in_if.value_missing <= miss;
		in_if.block_length <= len;
		in_if.last_block <= last;
		do @(posedge clk); while (!in_if.ready);
		take_item(v, miss, len, last);
	endtask

	// Stop offering and wait for every expected result, then a short settle.
	task automatic drain();
		in_if.valid <= 1'b0;
		burst_left = 0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [wbj_pkg::RIDX_W-1:0] idx, logic [31:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.reg_index <= idx;
		cfg_if.wdata <= data;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		if (idx == wbj_pkg::REG_TOTAL_GIVEN) mode_total = data[0];
		else full_total = longint'(int'(data));
		@(posedge clk);
	endtask

	task automatic configure(bit given, logic [31:0] tot);
		drain();
		write_reg(wbj_pkg::REG_TOTAL_GIVEN, {31'b0, given});
		write_reg(wbj_pkg::REG_TOTAL_ESTIMATE, tot);
	endtask

	function automatic logic [31:0] random_value();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'($urandom_range(0, 64) - 32) << 24;
			default: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
		endcase
	endfunction

	function automatic logic [23:0] random_length();
		case ($urandom_range(0, 39))
			0: return 24'd0;
			1, 2: return 24'($urandom());
			default: return 24'($urandom_range(1, 1000));
		endcase
	endfunction

	// Extreme values and lengths in mean mode.
	task automatic test_extremes();
		configure(1'b0, 32'd0);
		send_item(32'h7FFF_FFFF, 1'b0, 24'hFF_FFFF, 1'b0);
		send_item(32'h8000_0000, 1'b0, 24'd1, 1'b0);
		send_item(32'h0000_0000, 1'b0, 24'd1000, 1'b1);
		send_item(32'h8000_0000, 1'b0, 24'hFF_FFFF, 1'b0);
		send_item(32'h7FFF_FFFF, 1'b0, 24'hFF_FFFF, 1'b1);
	endtask

	// A missing item still closes the set; a set of nothing but it has no blocks.
	task automatic test_missing();
		send_item(32'h0100_0000, 1'b0, 24'd5, 1'b0);
		send_item(32'hFF00_0000, 1'b0, 24'd7, 1'b0);
		send_item(32'h1234_5678, 1'b1, 24'd9, 1'b1);
		send_item(32'hFFFF_FFFF, 1'b1, 24'hFF_FFFF, 1'b1);
	endtask

	// Zero denominators in mean mode: a zero length, and a single block.
	task automatic test_zero_denominator();
		send_item(32'h0200_0000, 1'b0, 24'd0, 1'b0);
		send_item(32'h0300_0000, 1'b0, 24'd4, 1'b1);
		send_item(32'h0300_0000, 1'b0, 24'd3, 1'b1);
	endtask

	// Pseudo-value mode with extreme totals, and its own zero denominators.
	task automatic test_pseudo_values();
		configure(1'b1, 32'h7FFF_FFFF);
		send_item(32'h8000_0000, 1'b0, 24'd10, 1'b0);
		send_item(32'h0100_0000, 1'b0, 24'd20, 1'b0);
		send_item(32'h7FFF_FFFF, 1'b0, 24'hFF_FFFF, 1'b1);
		configure(1'b1, 32'h8000_0000);
		send_item(32'h7FFF_FFFF, 1'b0, 24'd3, 1'b0);
		send_item(32'h0000_0001, 1'b0, 24'd8, 1'b1);
		send_item(32'h0100_0000, 1'b0, 24'd12, 1'b1);
		send_item(32'h0100_0000, 1'b0, 24'd0, 1'b0);
		send_item(32'h0200_0000, 1'b0, 24'd0, 1'b1);
		// Only the low bit of the mode register counts.
		configure(1'b0, 32'h0100_0000);
		write_reg(wbj_pkg::REG_TOTAL_GIVEN, 32'hFFFF_FFFE);
		send_item(32'h0100_0000, 1'b0, 24'd2, 1'b0);
		send_item(32'h0180_0000, 1'b0, 24'd6, 1'b1);
	endtask

	// More items than the store holds: the excess is dropped.
	task automatic test_overflow();
		configure(1'b0, 32'd0);
		for (int i = 0; i < wbj_pkg::MAX_BLOCKS + 6; i++)
			send_item(random_value(), 1'b0, 24'($urandom_range(1, 50)),
				i == wbj_pkg::MAX_BLOCKS + 5);
	endtask

	// The receiver holds off while the sender keeps offering several sets.
	task automatic test_backpressure();
		hold_req = 1'b1;
		for (int s = 0; s < 4; s++)
			for (int i = 0; i < 4; i++)
				send_item(random_value(), 1'b0, random_length(), i == 3);
		drain();
	endtask

	// Random data sets under changing settings.
	task automatic test_random_sets();
		int sent, size, sets;
		sent = 0;
		sets = 0;
		while (sent < 200) begin
			if (sets % 12 == 0) begin
				case ($urandom_range(0, 4))
					0: configure($urandom_range(0, 1), 32'h7FFF_FFFF);
					1: configure($urandom_range(0, 1), 32'h8000_0000);
					2: configure($urandom_range(0, 1), random_value());
					default: configure($urandom_range(0, 1), $urandom());
				endcase
			end
			if ($urandom_range(0, 7) == 0) gaps_on = !gaps_on;
			case ($urandom_range(0, 19))
				0: size = 1;
				1: size = $urandom_range(20, 40);
				default: size = $urandom_range(2, 10);
			endcase
			for (int i = 0; i < size; i++)
				send_item(random_value(), $urandom_range(0, 19) == 0, random_length(),
					i == size - 1);
			sent += size;
			sets++;
		end
		gaps_on = 1'b1;
	endtask

	// Receiver: stall pattern changes now and then; long hold-off on request.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 3000;
		end
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left = $urandom_range(50, 400);
		end else begin
			mode_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_if.ready <= 1'b0;
		end else begin
			case (stall_mode)
				0: out_if.ready <= 1'b1;
				1: out_if.ready <= ($urandom_range(0, 3) != 0);
				default: out_if.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Compare each result with the oldest expectation.
	always @(posedge clk) begin
		jk_result_t e;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (expected_results.size() == 0) begin
				$error("result with no expectation waiting");
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (out_if.estimate !== e.estimate) begin
					$error("estimate: expected %h, got %h", e.estimate, out_if.estimate);
					errors++;
				end
				if (out_if.variance !== e.variance) begin
					$error("variance: expected %h, got %h", e.variance, out_if.variance);
					errors++;
				end
				if (out_if.status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, out_if.status);
					errors++;
				end
				if (out_if.blocks_used !== e.blocks_used) begin
					$error("blocks_used: expected %0d, got %0d", e.blocks_used,
						out_if.blocks_used);
					errors++;
				end
			end
		end
	end

	initial begin
		#40ms;
		$display("tb_top: errors");
		$finish;
	end

	initial begin
		mode_total = 1'b0;
		full_total = 0;
		clear_set();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_missing();
		test_zero_denominator();
		test_pseudo_values();
		test_overflow();
		test_backpressure();
		test_random_sets();
		drain();
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			if (expected_results.size() != 0)
				$error("%0d expected results never arrived", expected_results.size());
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
`default_nettype wire

@@ sim.f @@
sv/wbj_pkg.sv
sv/wbj_ifs.sv
sv/wbj_div.sv
sv/wbj_mul.sv
sv/weighted_block_jackknife_top.sv
test/tb_top.sv
